// ----- rtl/core/diagonal_gaussian_likelihood_4d_unit_assert.svh -----
// Assertion macros for the diagonal Gaussian likelihood unit.
`ifndef DIAGONAL_GAUSSIAN_LIKELIHOOD_4D_UNIT_ASSERT_SVH
`define DIAGONAL_GAUSSIAN_LIKELIHOOD_4D_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DGL_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Next-cycle implication.
`define DGL_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
// Implication after a fixed number of cycles.
`define DGL_ASSERT_DLY(label, pre, n, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> ##(n) (post)) \
        else $error(msg);
`else
`define DGL_ASSERT_IMP(label, pre, post, msg)
`define DGL_ASSERT_NXT(label, pre, post, msg)
`define DGL_ASSERT_DLY(label, pre, n, post, msg)
`endif
`endif

// ----- rtl/core/dgl4d_pkg.sv -----
// Types and constants of the diagonal Gaussian likelihood unit.
`timescale 1ns / 1ps
package dgl4d_pkg;

    localparam int NUM_AXES = 4;
    localparam int EXP_TERMS = 10;
    localparam int FRONT_STAGES = 8;
    localparam int BACK_STAGES = 2;
    localparam int LATENCY = FRONT_STAGES + 2 * EXP_TERMS + BACK_STAGES;
    localparam int RECIP_SHIFT = 34;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [40:0] TERM_CAP = 41'h100_0000_0000;
    localparam logic [26:0] EXP_N_MAX = 27'd32;
    localparam logic [5:0] EXP_BIAS = 6'd30;
    localparam logic [31:0] CFG_RESET = 32'h0001_0000;

    localparam logic [2:0] REG_INV_VAR_0 = 3'd0;
    localparam logic [2:0] REG_INV_VAR_1 = 3'd1;
    localparam logic [2:0] REG_INV_VAR_2 = 3'd2;
    localparam logic [2:0] REG_INV_VAR_3 = 3'd3;
    localparam logic [2:0] REG_NORM_COEFF = 3'd4;

    // Integer exponent and underflow flag that travel beside the mantissa.
    typedef struct packed {
        logic [5:0] n;
        logic       zero;
    } exp_ctl_t;

endpackage

// ----- rtl/core/diagonal_gaussian_likelihood_4d_unit.sv -----
// Throughput: one item per cycle; busy never rises, as every stage advances each cycle.
// The ten-step exp Horner chain (two multiplier stages per step) sets the depth.
// Results are single-cycle done pulses; the receiver cannot stall the pipeline.
// Reset clears the valid pipeline and sets all five registers to 1.0 (0x00010000).
`timescale 1ns / 1ps
`include "diagonal_gaussian_likelihood_4d_unit_assert.svh"

module diagonal_gaussian_likelihood_4d_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic signed [31:0] coord_0,
    input  logic signed [31:0] coord_1,
    input  logic signed [31:0] coord_2,
    input  logic signed [31:0] coord_3,
    input  logic signed [31:0] mean_0,
    input  logic signed [31:0] mean_1,
    input  logic signed [31:0] mean_2,
    input  logic signed [31:0] mean_3,
    output logic               done,
    output logic [31:0]        likelihood
);

    localparam int NA = dgl4d_pkg::NUM_AXES;
    localparam int NT = dgl4d_pkg::EXP_TERMS;
    localparam int LAT = dgl4d_pkg::LATENCY;

    logic              item_accept;
    logic [LAT-1:0]    valid_reg;

    logic [31:0]       inv_var_reg [NA];
    logic [31:0]       norm_coeff_reg;

    logic [31:0]       coord_in [NA];
    logic [31:0]       mean_in [NA];

    logic [31:0]       abs_reg [NA];
    logic [47:0]       sq_reg [NA];
    logic [39:0]       hi_reg [NA];
    logic              hi_big_reg [NA];
    logic [31:0]       lo_reg [NA];
    logic [40:0]       term_reg [NA];

    logic [41:0]       pair_next [2];
    logic [41:0]       pair_reg [2];
    logic [42:0]       q_next;
    logic [41:0]       h_reg;

    logic [58:0]       y_full;
    logic [15:0]       f_reg;
    dgl4d_pkg::exp_ctl_t f_ctl_next;
    dgl4d_pkg::exp_ctl_t f_ctl_reg;

    logic [45:0]       x_full;
    logic [29:0]       x_reg;
    dgl4d_pkg::exp_ctl_t x_ctl_reg;

    logic [29:0]       ha_x_reg [NT-1];
    logic [29:0]       ha_v_reg [NT];
    dgl4d_pkg::exp_ctl_t ha_ctl_reg [NT];
    logic [29:0]       hb_x_reg [NT-1];
    logic [30:0]       hb_p_reg [NT];
    dgl4d_pkg::exp_ctl_t hb_ctl_reg [NT];

    logic [61:0]       prod_next;
    logic [61:0]       prod_reg;
    dgl4d_pkg::exp_ctl_t prod_ctl_reg;

    logic [5:0]        s_shift;
    logic [62:0]       round_bit;
    logic [62:0]       round_sum;
    logic [62:0]       shifted;
    logic [31:0]       likelihood_next;
    logic [31:0]       likelihood_reg;

    assign busy = 1'b0;
    assign item_accept = start && !busy;

    assign coord_in[0] = coord_0;
    assign coord_in[1] = coord_1;
    assign coord_in[2] = coord_2;
    assign coord_in[3] = coord_3;
    assign mean_in[0] = mean_0;
    assign mean_in[1] = mean_1;
    assign mean_in[2] = mean_2;
    assign mean_in[3] = mean_3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NA; i++)
            begin
                inv_var_reg[i] <= dgl4d_pkg::CFG_RESET;
            end
            norm_coeff_reg <= dgl4d_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dgl4d_pkg::REG_INV_VAR_0:  inv_var_reg[0] <= cfg_data;
                dgl4d_pkg::REG_INV_VAR_1:  inv_var_reg[1] <= cfg_data;
                dgl4d_pkg::REG_INV_VAR_2:  inv_var_reg[2] <= cfg_data;
                dgl4d_pkg::REG_INV_VAR_3:  inv_var_reg[3] <= cfg_data;
                dgl4d_pkg::REG_NORM_COEFF: norm_coeff_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LAT-2:0], item_accept};
        end
    end

    // Per-axis lanes: difference, square, weighting by the inverse variance.
    for (genvar i = 0; i < NA; i++) begin : g_axis
        logic [32:0] diff;
        logic [32:0] abs_next;
        logic [63:0] sq_full;
        logic [63:0] hi_full;
        logic [47:0] lo_full;
        logic [40:0] tsum;
        logic [40:0] term_next;

        assign diff = {coord_in[i][31], coord_in[i]} - {mean_in[i][31], mean_in[i]};
        assign abs_next = diff[32] ? (33'd0 - diff) : diff;
        assign sq_full = 64'(abs_reg[i]) * 64'(abs_reg[i]);
        assign hi_full = 64'(inv_var_reg[i]) * 64'(sq_reg[i][47:16]);
        assign lo_full = 48'(inv_var_reg[i]) * 48'(sq_reg[i][15:0]);
        assign tsum = {1'b0, hi_reg[i]} + {9'd0, lo_reg[i]};
        assign term_next = (hi_big_reg[i] || tsum > dgl4d_pkg::TERM_CAP)
                         ? dgl4d_pkg::TERM_CAP : tsum;

        always_ff @(posedge clk)
        begin
            abs_reg[i]    <= abs_next[31:0];
            sq_reg[i]     <= sq_full[63:16];
            hi_reg[i]     <= hi_full[39:0];
            hi_big_reg[i] <= |hi_full[63:40];
            lo_reg[i]     <= lo_full[47:16];
            term_reg[i]   <= term_next;
        end
    end

    assign pair_next[0] = {1'b0, term_reg[0]} + {1'b0, term_reg[1]};
    assign pair_next[1] = {1'b0, term_reg[2]} + {1'b0, term_reg[3]};
    assign q_next = {1'b0, pair_reg[0]} + {1'b0, pair_reg[1]};

    // Split q/2 * log2(e) into an integer shift and a 16-bit fraction.
    assign y_full = 59'(h_reg) * 59'(dgl4d_pkg::LOG2E_Q16);
    assign f_ctl_next.n = y_full[37:32];
    assign f_ctl_next.zero = y_full[58:32] > dgl4d_pkg::EXP_N_MAX;
    assign x_full = 46'(f_reg) * 46'(dgl4d_pkg::LN2_Q30);

    always_ff @(posedge clk)
    begin
        pair_reg[0] <= pair_next[0];
        pair_reg[1] <= pair_next[1];
        h_reg       <= q_next[42:1];
        f_reg       <= y_full[31:16];
        f_ctl_reg   <= f_ctl_next;
        x_reg       <= x_full[45:16];
        x_ctl_reg   <= f_ctl_reg;
    end

    // Horner chain for 2^-f, highest term first; each step is multiply, then divide by k.
    for (genvar j = 0; j < NT; j++) begin : g_horner
        localparam int unsigned K = NT - j;
        localparam logic [34:0] RECIP =
            35'(((64'd1 << dgl4d_pkg::RECIP_SHIFT) + 64'(K) - 64'd1) / 64'(K));

        logic [29:0]         x_in;
        logic [30:0]         p_in;
        dgl4d_pkg::exp_ctl_t ctl_in;
        logic [59:0]         xp_full;
        logic [63:0]         quo_full;
        logic [30:0]         p_next;

        if (j == 0) begin : g_first
            assign x_in = x_reg;
            assign p_in = dgl4d_pkg::ONE_Q30;
            assign ctl_in = x_ctl_reg;
        end
        else begin : g_rest
            assign x_in = hb_x_reg[j-1];
            assign p_in = hb_p_reg[j-1];
            assign ctl_in = hb_ctl_reg[j-1];
        end

        assign xp_full = 60'(x_in) * 60'(p_in);
        // Exact floor division by k through a rounded-up reciprocal.
        assign quo_full = 64'(ha_v_reg[j]) * 64'(RECIP);
        assign p_next = dgl4d_pkg::ONE_Q30 - {1'b0, quo_full[63:34]};

        always_ff @(posedge clk)
        begin
            ha_v_reg[j]   <= xp_full[59:30];
            ha_ctl_reg[j] <= ctl_in;
            hb_p_reg[j]   <= p_next;
            hb_ctl_reg[j] <= ha_ctl_reg[j];
        end

        if (j < NT - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                ha_x_reg[j] <= x_in;
                hb_x_reg[j] <= ha_x_reg[j];
            end
        end
    end

    assign prod_next = 62'(norm_coeff_reg) * 62'(hb_p_reg[NT-1]);

    // Round to nearest while shifting out the Q1.30 scale plus the integer exponent.
    assign s_shift = dgl4d_pkg::EXP_BIAS + prod_ctl_reg.n;
    assign round_bit = 63'd1 << (s_shift - 6'd1);
    assign round_sum = {1'b0, prod_reg} + round_bit;
    assign shifted = round_sum >> s_shift;

    always_comb
    begin
        if (prod_ctl_reg.zero)
        begin
            likelihood_next = '0;
        end
        else if (|shifted[62:32])
        begin
            likelihood_next = '1;
        end
        else
        begin
            likelihood_next = shifted[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_next;
        prod_ctl_reg   <= hb_ctl_reg[NT-1];
        likelihood_reg <= likelihood_next;
    end

    assign done = valid_reg[LAT-1];
    assign likelihood = likelihood_reg;

    `DGL_ASSERT_DLY(a_accept_to_done, item_accept, LAT, done, "accepted beat produced no result")
    `DGL_ASSERT_IMP(a_done_from_accept, done, $past(item_accept, LAT), "result without an accepted beat")
    `DGL_ASSERT_IMP(a_exp_mantissa_range, valid_reg[LAT-3], (hb_p_reg[NT-1] <= dgl4d_pkg::ONE_Q30) && (hb_p_reg[NT-1] != '0), "exp mantissa out of range")
    `DGL_ASSERT_NXT(a_underflow_zero, valid_reg[LAT-2] && prod_ctl_reg.zero, done && (likelihood == '0), "underflow did not give zero")

endmodule

// ----- sim/diagonal_gaussian_likelihood_4d_unit_tb.sv -----
// Self-checking testbench for the diagonal 4-D Gaussian likelihood unit.
`timescale 1ns / 1ps

module diagonal_gaussian_likelihood_4d_unit_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [63:0] WEIGHT_CAP = 64'h100_0000_0000;
    localparam logic [63:0] LOG2E_FIX = 64'd94548;
    localparam logic [63:0] LN2_FIX = 64'd744261118;
    localparam logic [63:0] UNITY_Q30 = 64'h4000_0000;
    localparam int SERIES_TERMS = 10;
    localparam logic [31:0] UNITY_Q16 = 32'h0001_0000;
    localparam logic [31:0] COORD_MAX = 32'h7fff_ffff;
    localparam logic [31:0] COORD_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [3:0][31:0] coord;
        logic [3:0][31:0] mean;
    } particle_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;
    logic signed [31:0] coord_0, coord_1, coord_2, coord_3;
    logic signed [31:0] mean_0, mean_1, mean_2, mean_3;
    logic done;
    logic [31:0] likelihood;

    // Register image seen by the predictor.
    logic [31:0] inv_var_img [4];
    logic [31:0] coeff_img;

    logic [31:0] pending_likelihood [$];
    int mismatches = 0;
    int cycle_count = 0;
    int sender_idle_pct = 0;

    diagonal_gaussian_likelihood_4d_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .coord_0    (coord_0),
        .coord_1    (coord_1),
        .coord_2    (coord_2),
        .coord_3    (coord_3),
        .mean_0     (mean_0),
        .mean_1     (mean_1),
        .mean_2     (mean_2),
        .mean_3     (mean_3),
        .done       (done),
        .likelihood (likelihood)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("diagonal_gaussian_likelihood_4d_unit_tb failed");
            $finish;
        end
    end

    // Weighted squared distance along one axis, capped like the hardware term.
    function automatic logic [63:0] axis_weight(input logic [31:0] c, input logic [31:0] m,
                                                input logic [31:0] iv);
        logic signed [33:0] diff;
        logic [63:0] mag;
        logic [63:0] sq;
        logic [63:0] hi;
        logic [63:0] sum;
        diff = $signed({{2{c[31]}}, c}) - $signed({{2{m[31]}}, m});
        mag = diff[33] ? 64'(-diff) : 64'(diff);
        sq = (mag * mag) >> 16;
        hi = 64'(iv) * (sq >> 16);
        if (hi >= WEIGHT_CAP)
            return WEIGHT_CAP;
        sum = hi + ((64'(iv) * 64'(sq[15:0])) >> 16);
        return (sum > WEIGHT_CAP) ? WEIGHT_CAP : sum;
    endfunction

    function automatic logic [31:0] gaussian_likelihood(input particle_t pt);
        logic [63:0] quad;
        logic [63:0] half_q;
        logic [63:0] log2_arg;
        logic [63:0] whole;
        logic [63:0] frac_ln;
        logic [63:0] mant;
        logic [63:0] shift;
        logic [63:0] scaled;
        int k;
        quad = 64'd0;
        for (k = 0; k < 4; k++)
            quad += axis_weight(pt.coord[k], pt.mean[k], inv_var_img[k]);
        half_q = quad >> 1;
        log2_arg = (half_q * LOG2E_FIX) >> 16;
        whole = log2_arg >> 16;
        frac_ln = (64'(log2_arg[15:0]) * LN2_FIX) >> 16;
        // Horner evaluation of 2^-frac as a truncated series of exp(-x).
        mant = UNITY_Q30;
        for (k = SERIES_TERMS; k >= 1; k--)
            mant = UNITY_Q30 - (((frac_ln * mant) >> 30) / 64'(k));
        shift = 64'd30 + whole;
        if (shift > 64'd62)
            return 32'd0;
        scaled = (64'(coeff_img) * mant + (64'd1 << (shift - 64'd1))) >> shift;
        return (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
    endfunction

    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && done)
        begin
            if (pending_likelihood.size() == 0)
            begin
                $error("likelihood: no result expected, got %h", likelihood);
                mismatches++;
            end
            else
            begin
                want = pending_likelihood.pop_front();
                if (likelihood !== want)
                begin
                    $error("likelihood: expected %h, actual %h", want, likelihood);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_particle(input particle_t pt);
        // Each cycle is idle with the configured probability.
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        coord_0 <= pt.coord[0];
        coord_1 <= pt.coord[1];
        coord_2 <= pt.coord[2];
        coord_3 <= pt.coord[3];
        mean_0 <= pt.mean[0];
        mean_1 <= pt.mean[1];
        mean_2 <= pt.mean[2];
        mean_3 <= pt.mean[3];
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_likelihood.push_back(gaussian_likelihood(pt));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_likelihood.size() != 0)
            @(posedge clk);
    endtask

    // Leaves the write enable high; the caller lowers it after its last write.
    task automatic write_register(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == dgl4d_pkg::REG_NORM_COEFF)
            coeff_img = val;
        else if (idx < dgl4d_pkg::REG_NORM_COEFF)
            inv_var_img[idx[1:0]] = val;
    endtask

    task automatic program_settings(input logic [31:0] iv0, input logic [31:0] iv1,
                                    input logic [31:0] iv2, input logic [31:0] iv3,
                                    input logic [31:0] coeff);
        wait_drained();
        write_register(dgl4d_pkg::REG_INV_VAR_0, iv0);
        write_register(dgl4d_pkg::REG_INV_VAR_1, iv1);
        write_register(dgl4d_pkg::REG_INV_VAR_2, iv2);
        write_register(dgl4d_pkg::REG_INV_VAR_3, iv3);
        write_register(dgl4d_pkg::REG_NORM_COEFF, coeff);
        cfg_we <= 1'b0;
    endtask

    function automatic particle_t uniform_offset(input logic [31:0] c, input logic [31:0] m);
        particle_t pt;
        pt.coord = {4{c}};
        pt.mean = {4{m}};
        return pt;
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(3))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return 32'd0;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic particle_t random_particle();
        particle_t pt;
        logic [31:0] delta;
        bit near_only;
        int k;
        near_only = ($urandom_range(3) != 0);
        for (k = 0; k < 4; k++)
        begin
            pt.mean[k] = $urandom;
            delta = $urandom_range(0, 1 << $urandom_range(4, 18));
            if ($urandom_range(1))
                delta = -delta;
            pt.coord[k] = pt.mean[k] + delta;
            if (!near_only)
                case ($urandom_range(3))
                    0: pt.coord[k] = $urandom;
                    1:
                    begin
                        pt.coord[k] = pick_extreme();
                        pt.mean[k] = pick_extreme();
                    end
                    2: pt.coord[k] = pt.mean[k];
                    default: ;
                endcase
        end
        return pt;
    endfunction

    task automatic test_reset_values();
        particle_t pt;
        int k;
        send_particle(uniform_offset(32'd0, 32'd0));
        send_particle(uniform_offset(COORD_MAX, COORD_MAX));
        send_particle(uniform_offset(COORD_MIN, COORD_MIN));
        send_particle(uniform_offset(COORD_MIN, COORD_MAX));
        send_particle(uniform_offset(COORD_MAX, COORD_MIN));
        send_particle(uniform_offset(32'd1, 32'd0));
        // A distance of exactly one along each axis in turn.
        for (k = 0; k < 4; k++)
        begin
            pt = uniform_offset(32'd0, 32'd0);
            pt.coord[k] = UNITY_Q16;
            send_particle(pt);
        end
    endtask

    task automatic test_extreme_settings();
        logic [2:0] idx;
        program_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_particle(uniform_offset(COORD_MAX, COORD_MIN));
        send_particle(random_particle());
        // All weights at full scale: zero distance keeps the full coefficient,
        // the largest distance drives every term into its cap.
        program_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF);
        send_particle(uniform_offset(32'd5, 32'd5));
        send_particle(uniform_offset(32'd1, 32'd0));
        send_particle(uniform_offset(COORD_MIN, COORD_MAX));
        program_settings(UNITY_Q16, UNITY_Q16, UNITY_Q16, UNITY_Q16, 32'd0);
        send_particle(uniform_offset(32'd0, 32'd0));
        // Writes above the last register must leave every register unchanged.
        wait_drained();
        for (idx = dgl4d_pkg::REG_NORM_COEFF + 3'd1; idx != 3'd0; idx++)
            write_register(idx, $urandom);
        cfg_we <= 1'b0;
        send_particle(uniform_offset(32'd0, 32'd0));
    endtask

    task automatic test_underflow_edge();
        particle_t pt;
        int k;
        program_settings(UNITY_Q16, UNITY_Q16, UNITY_Q16, UNITY_Q16, 32'hFFFF_FFFF);
        // Distances from 6.5 to 6.94 cross the point where the result flushes to zero.
        for (k = 0; k < 8; k++)
        begin
            pt = uniform_offset(32'd0, 32'd0);
            pt.coord[0] = 32'd425984 + 32'(k) * 32'd4096;
            send_particle(pt);
        end
    endtask

    function automatic logic [31:0] random_weight();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return $urandom;
            default: return $urandom_range(0, 1 << 18);
        endcase
    endfunction

    task automatic test_random_traffic();
        int phase;
        int seg;
        int n;
        for (phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 47 : 0;
            for (seg = 0; seg < 4; seg++)
            begin
                program_settings(random_weight(), random_weight(), random_weight(),
                                 random_weight(), $urandom);
                for (n = 0; n < 40; n++)
                    send_particle(random_particle());
            end
        end
        sender_idle_pct = 0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= dgl4d_pkg::REG_INV_VAR_0;
        cfg_data <= 32'd0;
        coord_0 <= 32'd0;
        coord_1 <= 32'd0;
        coord_2 <= 32'd0;
        coord_3 <= 32'd0;
        mean_0 <= 32'd0;
        mean_1 <= 32'd0;
        mean_2 <= 32'd0;
        mean_3 <= 32'd0;
        for (int k = 0; k < 4; k++)
            inv_var_img[k] = UNITY_Q16;
        coeff_img = UNITY_Q16;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_extreme_settings();
        test_underflow_edge();
        test_random_traffic();

        wait_drained();
        repeat (dgl4d_pkg::LATENCY + 8) @(posedge clk);
        if (pending_likelihood.size() != 0)
        begin
            $error("likelihood: %0d results never arrived", pending_likelihood.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("diagonal_gaussian_likelihood_4d_unit_tb passed");
        else
            $display("diagonal_gaussian_likelihood_4d_unit_tb failed");
        $finish;
    end

endmodule
